FILE: rtl/wes_pkg.sv
// Shared types, constants and helper functions for the weighted edge store.
package wes_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int RESULT_CAP   = 32;

  localparam int CELLS     = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam int VBITS     = $clog2(MAX_VERTICES);
  localparam int LIM_BITS  = $clog2(MAX_VERTICES + 1);
  localparam int CAP_BITS  = $clog2(RESULT_CAP + 1);
  localparam int CMP_BITS  = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

  localparam int VERT_BITS  = 5;
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 6;
  localparam int INDEX_BITS = 2;

  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [VBITS-1:0]              vidx_t;
  typedef logic [LIM_BITS-1:0]           lim_t;
  typedef logic [CAP_BITS-1:0]           cap_t;
  typedef logic [VERT_BITS-1:0]          vport_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [CMP_BITS-1:0]    cmpw_t;
  typedef logic signed [FIELD_BITS-1:0]  wport_t;

  typedef enum logic [1:0] {
    FUNC_INSERT,
    FUNC_REMOVE,
    FUNC_NEIGHBOURS,
    FUNC_LIGHTEST
  } func_t;

  typedef enum logic [INDEX_BITS-1:0] {
    CFG_DIRECTED,
    CFG_VERTEX_COUNT,
    CFG_CEILING
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_FWD,
    ST_EDGE_REV,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic    present;
    weight_t weight;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    logic   directed;
    lim_t   limit;
    wport_t ceiling;
  } cfg_t;

  typedef struct packed {
    logic   strobe;
    logic   status;
    logic   found;
    vport_t vertex_a;
    vport_t vertex_b;
    wport_t weight;
    logic   last;
  } res_t;

  function automatic addr_t cell_addr(input vidx_t row, input vidx_t col);
    return addr_t'(int'(row) * MAX_VERTICES + int'(col));
  endfunction

  function automatic weight_t sat_weight(input wport_t w);
    longint hi;
    longint lo;
    longint x;
    hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
    lo = -hi - 1;
    x  = longint'(w);
    if (x > hi) begin
      return weight_t'(hi);
    end
    if (x < lo) begin
      return weight_t'(lo);
    end
    return weight_t'(x);
  endfunction

  function automatic wport_t port_weight(input cmpw_t w);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

FILE: rtl/wes_mem.sv
// Edge matrix memory: one write port and one registered read port.
module wes_mem
  import wes_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  addr_t   raddr,
  output entry_t  rdata
);

  entry_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/wes_seq.sv
// Sequencer: clearing sweep, edge read-modify-write and matrix scans.
module wes_seq
  import wes_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    func,
  input  vport_t        src_vertex,
  input  vport_t        dst_vertex,
  input  wport_t        edge_weight_in,
  input  cfg_t          cfg,
  output logic          busy,
  output res_t          res,
  output mem_wr_t       mem_wr,
  output addr_t         mem_raddr,
  input  entry_t        mem_rdata
);

  state_t  state;
  state_t  state_next;
  func_t   op;
  vport_t  s_q;
  vport_t  d_q;
  weight_t w_q;
  logic    had;
  vidx_t   ri;
  vidx_t   ci;
  logic    rd_vld;
  vidx_t   rd_row;
  vidx_t   rd_col;
  logic    pend_vld;
  vidx_t   pend_col;
  weight_t pend_w;
  cap_t    cnt;
  logic    got;
  cmpw_t   low;
  vidx_t   best_row;
  vidx_t   best_col;
  addr_t   clr_addr;
  res_t    res_next;

  vidx_t s_v;
  vidx_t d_v;
  vidx_t lim_last;
  logic  s_ok;
  logic  d_ok;
  logic  ci_end;
  logic  ri_end;
  logic  nb_take;
  logic  lt_take;
  cmpw_t rd_w;
  entry_t wr_entry;

  assign s_v      = vidx_t'(s_q);
  assign d_v      = vidx_t'(d_q);
  assign lim_last = vidx_t'(cfg.limit - 1'b1);
  assign s_ok     = int'(s_q) < int'(cfg.limit);
  assign d_ok     = int'(d_q) < int'(cfg.limit);
  assign ci_end   = ci == lim_last;
  assign ri_end   = ri == lim_last;
  assign rd_w     = cmpw_t'($signed(mem_rdata.weight));
  assign nb_take  = rd_vld && op == FUNC_NEIGHBOURS && mem_rdata.present
                    && int'(cnt) < RESULT_CAP;
  assign lt_take  = rd_vld && op == FUNC_LIGHTEST && mem_rdata.present && rd_w < low;
  assign wr_entry = '{present: op == FUNC_INSERT, weight: w_q};
  assign busy     = state != ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == addr_t'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op)
          FUNC_INSERT, FUNC_REMOVE: state_next = (s_ok && d_ok) ? ST_EDGE_FWD : ST_IDLE;
          FUNC_NEIGHBOURS:          state_next = s_ok ? ST_SCAN : ST_IDLE;
          FUNC_LIGHTEST:            state_next = (cfg.limit != '0) ? ST_SCAN : ST_REPORT;
          default:                  state_next = ST_IDLE;
        endcase
      end
      ST_EDGE_FWD: state_next = ST_EDGE_REV;
      ST_EDGE_REV: state_next = ST_IDLE;
      ST_SCAN: begin
        if (ci_end && (op == FUNC_NEIGHBOURS || ri_end)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_wr    = '{en: 1'b0, addr: cell_addr(s_v, d_v), data: wr_entry};
    mem_raddr = cell_addr(s_v, d_v);
    res_next  = '0;
    if (nb_take && pend_vld) begin
      res_next.strobe   = 1'b1;
      res_next.found    = 1'b1;
      res_next.vertex_a = vport_t'(pend_col);
      res_next.vertex_b = s_q;
      res_next.weight   = port_weight(cmpw_t'(pend_w));
    end
    case (state)
      ST_CLEAR: begin
        mem_wr = '{en: 1'b1, addr: clr_addr, data: '0};
      end
      ST_DECODE: begin
        if ((op == FUNC_INSERT || op == FUNC_REMOVE) ? !(s_ok && d_ok)
            : (op == FUNC_NEIGHBOURS && !s_ok)) begin
          res_next.strobe = 1'b1;
          res_next.status = 1'b1;
          res_next.last   = 1'b1;
        end
      end
      ST_EDGE_FWD: begin
        mem_wr.en = 1'b1;
      end
      ST_EDGE_REV: begin
        mem_wr.en         = !cfg.directed;
        mem_wr.addr       = cell_addr(d_v, s_v);
        res_next.strobe   = 1'b1;
        res_next.found    = had;
        res_next.vertex_a = s_q;
        res_next.vertex_b = d_q;
        res_next.weight   = (op == FUNC_INSERT) ? port_weight(cmpw_t'(w_q)) : '0;
        res_next.last     = 1'b1;
      end
      ST_SCAN: begin
        mem_raddr = (op == FUNC_NEIGHBOURS) ? cell_addr(s_v, ci) : cell_addr(ri, ci);
      end
      ST_REPORT: begin
        res_next.strobe = 1'b1;
        res_next.last   = 1'b1;
        if (op == FUNC_NEIGHBOURS) begin
          res_next.vertex_b = s_q;
          if (pend_vld) begin
            res_next.found    = 1'b1;
            res_next.vertex_a = vport_t'(pend_col);
            res_next.weight   = port_weight(cmpw_t'(pend_w));
          end
        end else if (got) begin
          res_next.found  = 1'b1;
          res_next.weight = port_weight(low);
          if (!cfg.directed && best_col < best_row) begin
            res_next.vertex_a = vport_t'(best_col);
            res_next.vertex_b = vport_t'(best_row);
          end else begin
            res_next.vertex_a = vport_t'(best_row);
            res_next.vertex_b = vport_t'(best_col);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_vld   <= 1'b0;
      res      <= '0;
    end else begin
      state  <= state_next;
      res    <= res_next;
      rd_vld <= state == ST_SCAN;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op  <= func_t'(func);
      s_q <= src_vertex;
      d_q <= dst_vertex;
      w_q <= sat_weight(edge_weight_in);
    end
    if (state == ST_DECODE) begin
      ri       <= '0;
      ci       <= '0;
      pend_vld <= 1'b0;
      cnt      <= '0;
      got      <= 1'b0;
      low      <= cmpw_t'(cfg.ceiling);
    end
    if (state == ST_EDGE_FWD) begin
      had <= mem_rdata.present;
    end
    if (state == ST_SCAN) begin
      rd_row <= ri;
      rd_col <= ci;
      ci     <= ci_end ? '0 : ci + 1'b1;
      if (ci_end) begin
        ri <= ri + 1'b1;
      end
    end
    if (nb_take) begin
      pend_vld <= 1'b1;
      pend_col <= rd_col;
      pend_w   <= mem_rdata.weight;
      cnt      <= cnt + 1'b1;
    end
    if (lt_take) begin
      got      <= 1'b1;
      low      <= rd_w;
      best_row <= rd_row;
      best_col <= rd_col;
    end
  end

endmodule

FILE: rtl/weighted_edge_store.sv
// Top level of the weighted edge store: configuration registers, sequencer and memory.
//
//   channel   handshake                  payload
//   command   start, busy                func, src_vertex, dst_vertex, edge_weight_in
//   result    strobe (one cycle)         status, found, vertex_a, vertex_b, weight_out, last
//   config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// After reset the edge memory is cleared one entry per cycle, all 1024 entries, with busy high.
// Insert and remove pass decode, forward write and reverse write: one read and two writes (the second only undirected).
// An invalid vertex index gives its single error result, registered from the decode state.
// A neighbour listing scans one row and a lightest-edge search the whole vertex_limit by
// vertex_limit square (skipped with a limit of 0), one entry at a time through the one read port.
// One transaction is in flight at a time; results cannot be stalled by the receiver.
module weighted_edge_store
  import wes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  vport_t                src_vertex,
  input  vport_t                dst_vertex,
  input  wport_t                edge_weight_in,
  output logic                  strobe,
  output logic                  status,
  output logic                  found,
  output vport_t                vertex_a,
  output vport_t                vertex_b,
  output wport_t                weight_out,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  logic                  directed_mode;
  logic [COUNT_BITS-1:0] vertex_count;
  wport_t                search_ceiling;
  cfg_t                  cfg;
  res_t                  res;
  mem_wr_t               mem_wr;
  addr_t                 mem_raddr;
  entry_t                mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      directed_mode  <= 1'b0;
      vertex_count   <= COUNT_BITS'(MAX_VERTICES);
      search_ceiling <= 16'sh7fff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIRECTED:     directed_mode  <= cfg_data[0];
        CFG_VERTEX_COUNT: vertex_count   <= cfg_data[COUNT_BITS-1:0];
        CFG_CEILING:      search_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.directed = directed_mode;
    cfg.limit    = (int'(vertex_count) < MAX_VERTICES) ? lim_t'(vertex_count)
                                                       : lim_t'(MAX_VERTICES);
    cfg.ceiling  = search_ceiling;
  end

  wes_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .func           (func),
    .src_vertex     (src_vertex),
    .dst_vertex     (dst_vertex),
    .edge_weight_in (edge_weight_in),
    .cfg            (cfg),
    .busy           (busy),
    .res            (res),
    .mem_wr         (mem_wr),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  wes_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign strobe     = res.strobe;
  assign status     = res.status;
  assign found      = res.found;
  assign vertex_a   = res.vertex_a;
  assign vertex_b   = res.vertex_b;
  assign weight_out = res.weight;
  assign last       = res.last;

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("Block is not busy while the edge memory is being cleared.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  a_result_in_flight: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("Result appeared with no transaction in flight.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> last && !found)
    else $error("Error result is not a single final result.");

endmodule

FILE: verif/weighted_edge_store_tb.sv
// Self-checking testbench for weighted_edge_store with a predictor of the adjacency matrix.
module weighted_edge_store_tb
  import wes_pkg::*;
;

  typedef struct packed {
    logic   status;
    logic   found;
    vport_t vertex_a;
    vport_t vertex_b;
    wport_t weight;
    logic   last;
  } edge_report_t;

  localparam wport_t WEIGHT_MIN = 16'sh8000;
  localparam wport_t WEIGHT_MAX = 16'sh7FFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            func = '0;
  vport_t                src_vertex = '0;
  vport_t                dst_vertex = '0;
  wport_t                edge_weight_in = '0;
  logic                  strobe;
  logic                  status;
  logic                  found;
  vport_t                vertex_a;
  vport_t                vertex_b;
  wport_t                weight_out;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index = '0;
  logic [FIELD_BITS-1:0] cfg_data = '0;

  logic   graph_present [MAX_VERTICES][MAX_VERTICES] = '{default: '{default: 1'b0}};
  wport_t graph_weight [MAX_VERTICES][MAX_VERTICES] = '{default: '{default: '0}};
  logic         directed = 1'b0;
  logic [5:0]   vcount = 6'd32;
  wport_t       ceiling = WEIGHT_MAX;
  edge_report_t pending_reports[$];
  int           error_count = 0;
  bit           no_idle = 1'b0;

  weighted_edge_store DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .src_vertex(src_vertex),
    .dst_vertex(dst_vertex),
    .edge_weight_in(edge_weight_in),
    .strobe(strobe),
    .status(status),
    .found(found),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .weight_out(weight_out),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int vertex_limit();
    return (vcount < MAX_VERTICES) ? int'(vcount) : MAX_VERTICES;
  endfunction

  function automatic void predict_graph_reports(func_t f, vport_t s, vport_t d, wport_t w);
    int n;
    int hits;
    int k;
    int i;
    int j;
    int row;
    int col;
    int swap;
    logic got;
    wport_t lowest;
    edge_report_t r;
    n = vertex_limit();
    r = '0;
    case (f)
      FUNC_INSERT, FUNC_REMOVE: begin
        r.last = 1'b1;
        if (s >= n || d >= n) begin
          r.status = 1'b1;
        end else begin
          r.found = graph_present[s][d];
          r.vertex_a = s;
          r.vertex_b = d;
          if (f == FUNC_INSERT) begin
            graph_present[s][d] = 1'b1;
            graph_weight[s][d] = w;
            if (!directed) begin
              graph_present[d][s] = 1'b1;
              graph_weight[d][s] = w;
            end
            r.weight = w;
          end else begin
            graph_present[s][d] = 1'b0;
            if (!directed) begin
              graph_present[d][s] = 1'b0;
            end
          end
        end
        pending_reports.push_back(r);
      end
      FUNC_NEIGHBOURS: begin
        if (s >= n) begin
          r.status = 1'b1;
          r.last = 1'b1;
          pending_reports.push_back(r);
        end else begin
          hits = 0;
          for (j = 0; j < n; j++) begin
            if (graph_present[s][j]) begin
              hits++;
            end
          end
          if (hits > RESULT_CAP) begin
            hits = RESULT_CAP;
          end
          if (hits == 0) begin
            r.vertex_b = s;
            r.last = 1'b1;
            pending_reports.push_back(r);
          end else begin
            k = 0;
            for (j = 0; j < n && k < hits; j++) begin
              if (graph_present[s][j]) begin
                r.found = 1'b1;
                r.vertex_a = vport_t'(j);
                r.vertex_b = s;
                r.weight = graph_weight[s][j];
                r.last = (k == hits - 1);
                pending_reports.push_back(r);
                k++;
              end
            end
          end
        end
      end
      default: begin
        lowest = ceiling;
        got = 1'b0;
        row = 0;
        col = 0;
        for (i = 0; i < n; i++) begin
          for (j = 0; j < n; j++) begin
            if (graph_present[i][j] && graph_weight[i][j] < lowest) begin
              lowest = graph_weight[i][j];
              row = i;
              col = j;
              got = 1'b1;
            end
          end
        end
        // Undirected results always name the smaller vertex first.
        if (got && !directed && col < row) begin
          swap = row;
          row = col;
          col = swap;
        end
        r.found = got;
        r.vertex_a = got ? vport_t'(row) : '0;
        r.vertex_b = got ? vport_t'(col) : '0;
        r.weight = got ? lowest : '0;
        r.last = 1'b1;
        pending_reports.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    edge_report_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction arrived with nothing expected");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", int'(want.status), int'(status));
        check_field("found", int'(want.found), int'(found));
        check_field("vertex_a", int'(want.vertex_a), int'(vertex_a));
        check_field("vertex_b", int'(want.vertex_b), int'(vertex_b));
        check_field("weight_out", int'(want.weight), int'(weight_out));
        check_field("last", int'(want.last), int'(last));
      end
    end
  end

  task automatic send_command(func_t f, vport_t s, vport_t d, wport_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    start = 1'b1;
    func = f;
    src_vertex = s;
    dst_vertex = d;
    edge_weight_in = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_graph_reports(f, s, d, w);
    @(negedge clk);
    start = 1'b0;
    func = 2'($urandom);
    src_vertex = vport_t'($urandom);
    dst_vertex = vport_t'($urandom);
    edge_weight_in = wport_t'($urandom);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [FIELD_BITS-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DIRECTED: directed = value[0];
      CFG_VERTEX_COUNT: vcount = value[5:0];
      default: ceiling = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(bit dir, logic [5:0] count, wport_t ceil);
    wait_idle();
    write_register(CFG_DIRECTED, FIELD_BITS'(dir));
    write_register(CFG_VERTEX_COUNT, FIELD_BITS'(count));
    write_register(CFG_CEILING, ceil);
  endtask

  function automatic vport_t random_vertex();
    int n;
    int roll;
    n = vertex_limit();
    roll = $urandom_range(0, 9);
    if (n == 0 || roll == 0) begin
      return vport_t'($urandom_range(0, 31));
    end
    if (roll < 5 && n > 6) begin
      return vport_t'($urandom_range(0, 5));
    end
    return vport_t'($urandom_range(0, n - 1));
  endfunction

  function automatic wport_t random_weight();
    case ($urandom_range(0, 7))
      0: return WEIGHT_MIN;
      1: return WEIGHT_MAX;
      default: return wport_t'($urandom);
    endcase
  endfunction

  task automatic test_cleared_graph();
    send_command(FUNC_NEIGHBOURS, 5'd0, 5'd0, '0);
    send_command(FUNC_LIGHTEST, 5'd31, 5'd31, WEIGHT_MAX);
  endtask

  task automatic test_edge_updates();
    configure(1'b1, 6'd32, WEIGHT_MAX);
    send_command(FUNC_INSERT, 5'd0, 5'd31, WEIGHT_MIN);
    send_command(FUNC_INSERT, 5'd0, 5'd31, WEIGHT_MAX);
    send_command(FUNC_REMOVE, 5'd0, 5'd31, WEIGHT_MIN);
    send_command(FUNC_REMOVE, 5'd0, 5'd31, '0);
    configure(1'b0, 6'd32, WEIGHT_MAX);
    send_command(FUNC_INSERT, 5'd7, 5'd7, 16'sh0080);
    send_command(FUNC_INSERT, 5'd3, 5'd9, -16'sd256);
    send_command(FUNC_NEIGHBOURS, 5'd9, 5'd0, '0);
    send_command(FUNC_REMOVE, 5'd9, 5'd3, '0);
    send_command(FUNC_NEIGHBOURS, 5'd3, 5'd0, '0);
  endtask

  task automatic test_vertex_limits();
    configure(1'b0, 6'd1, WEIGHT_MAX);
    send_command(FUNC_INSERT, 5'd0, 5'd0, 16'sd1);
    send_command(FUNC_INSERT, 5'd1, 5'd0, 16'sd1);
    send_command(FUNC_REMOVE, 5'd0, 5'd31, '0);
    send_command(FUNC_NEIGHBOURS, 5'd1, 5'd0, '0);
    configure(1'b0, 6'd0, WEIGHT_MAX);
    send_command(FUNC_NEIGHBOURS, 5'd0, 5'd0, '0);
    send_command(FUNC_LIGHTEST, 5'd0, 5'd0, '0);
    configure(1'b0, 6'd63, WEIGHT_MAX);
    send_command(FUNC_INSERT, 5'd31, 5'd30, 16'sd5);
  endtask

  task automatic test_lightest_search();
    configure(1'b1, 6'd32, WEIGHT_MAX);
    send_command(FUNC_INSERT, 5'd20, 5'd2, WEIGHT_MIN);
    send_command(FUNC_INSERT, 5'd5, 5'd6, WEIGHT_MAX);
    send_command(FUNC_LIGHTEST, 5'd0, 5'd0, '0);
    configure(1'b0, 6'd32, WEIGHT_MAX);
    send_command(FUNC_LIGHTEST, 5'd0, 5'd0, '0);
    configure(1'b0, 6'd32, WEIGHT_MIN);
    send_command(FUNC_LIGHTEST, 5'd0, 5'd0, '0);
    configure(1'b1, 6'd32, -16'sd32767);
    send_command(FUNC_LIGHTEST, 5'd0, 5'd0, '0);
  endtask

  // Fills one row completely so that the neighbour listing hits the result cap.
  task automatic test_full_row();
    int offset;
    int k;
    configure(1'b1, 6'd32, WEIGHT_MAX);
    offset = $urandom_range(0, 31);
    for (k = 0; k < MAX_VERTICES; k++) begin
      send_command(FUNC_INSERT, 5'd12, vport_t'((k * 7 + offset) % MAX_VERTICES),
                   random_weight());
    end
    send_command(FUNC_NEIGHBOURS, 5'd12, 5'd0, '0);
  endtask

  task automatic random_burst(int items, bit steady);
    int roll;
    func_t f;
    no_idle = steady;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      f = (roll < 40) ? FUNC_INSERT : (roll < 60) ? FUNC_REMOVE :
          (roll < 85) ? FUNC_NEIGHBOURS : FUNC_LIGHTEST;
      send_command(f, random_vertex(), random_vertex(), random_weight());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    configure(1'b0, 6'd32, WEIGHT_MAX);
    random_burst(35, 1'b0);
    configure(1'b1, 6'd8, '0);
    random_burst(35, 1'b1);
    configure(1'b0, 6'd3, WEIGHT_MIN);
    random_burst(30, 1'b0);
    configure(1'b1, 6'd32, 16'sh1000);
    random_burst(35, 1'b0);
    configure(1'b0, 6'd16, wport_t'($urandom));
    random_burst(35, 1'b1);
    configure(1'b1, 6'd1, -16'sd1);
    random_burst(20, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_cleared_graph();
    test_edge_updates();
    test_vertex_limits();
    test_lightest_search();
    test_full_row();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/wes_pkg.sv
rtl/wes_mem.sv
rtl/wes_seq.sv
rtl/weighted_edge_store.sv
verif/weighted_edge_store_tb.sv
